FILE: rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off while in reset
`define ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while in reset
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/svd_pkg.sv
package svd_pkg;

    localparam int VALUE_W = 64;
    localparam int SHIFT_W = 7;

    localparam logic [SHIFT_W-1:0] FIRST_SHIFT = 7'd6;
    localparam logic [SHIFT_W-1:0] LAST_SHIFT  = 7'd62;
    localparam logic [SHIFT_W-1:0] SHIFT_STEP  = 7'd7;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_TERM  = 2'd1,
        ST_TOO_LONG = 2'd2,
        ST_OVERFLOW = 2'd3
    } status_t;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        status_t            status;
    } result_t;

endpackage

FILE: rtl/svd_core.sv
module svd_core (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_fire,
    input  logic [7:0]       data_byte,
    input  logic             payload_end,
    output logic             res_valid,
    output svd_pkg::result_t res
);

    logic [svd_pkg::VALUE_W-1:0] acc_reg, acc_next;
    logic [svd_pkg::SHIFT_W-1:0] shift_reg, shift_next;
    logic                        neg_reg, neg_next;
    logic                        busy_reg, busy_next;

    logic [svd_pkg::VALUE_W-1:0] mag;
    logic [svd_pkg::VALUE_W-1:0] addend;
    logic                        neg;

    assign addend = {57'd0, data_byte[6:0]} << shift_reg[5:0];

    always_comb
    begin
        acc_next   = acc_reg;
        shift_next = shift_reg;
        neg_next   = neg_reg;
        busy_next  = busy_reg;
        res_valid  = 1'b0;
        res.value  = '0;
        res.status = svd_pkg::ST_OK;
        mag        = acc_reg;
        neg        = neg_reg;

        if (in_fire)
        begin
            // every result returns the state to its reset values
            acc_next   = '0;
            shift_next = svd_pkg::FIRST_SHIFT;
            neg_next   = 1'b0;
            busy_next  = 1'b0;

            if (busy_reg && shift_reg > svd_pkg::LAST_SHIFT)
            begin
                res_valid  = 1'b1;
                res.status = svd_pkg::ST_TOO_LONG;
            end
            else
            begin
                if (!busy_reg)
                begin
                    mag = {58'd0, data_byte[5:0]};
                    neg = data_byte[6];
                end
                else
                begin
                    mag = acc_reg | addend;
                end

                if (data_byte[7])
                begin
                    if (payload_end)
                    begin
                        res_valid  = 1'b1;
                        res.status = svd_pkg::ST_NO_TERM;
                    end
                    else
                    begin
                        acc_next   = mag;
                        neg_next   = neg;
                        busy_next  = 1'b1;
                        shift_next = busy_reg ? shift_reg + svd_pkg::SHIFT_STEP
                                              : svd_pkg::FIRST_SHIFT;
                    end
                end
                else if (mag[svd_pkg::VALUE_W-1])
                begin
                    res_valid  = 1'b1;
                    res.status = svd_pkg::ST_OVERFLOW;
                end
                else
                begin
                    res_valid  = 1'b1;
                    res.value  = neg ? (~mag + 64'd1) : mag;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg   <= '0;
            shift_reg <= svd_pkg::FIRST_SHIFT;
            neg_reg   <= 1'b0;
            busy_reg  <= 1'b0;
        end
        else
        begin
            acc_reg   <= acc_next;
            shift_reg <= shift_next;
            neg_reg   <= neg_next;
            busy_reg  <= busy_next;
        end
    end

endmodule

FILE: rtl/svd_skid.sv
module svd_skid (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  svd_pkg::result_t in_res,
    output logic             in_ready,
    output logic             out_valid,
    output svd_pkg::result_t out_res,
    input  logic             out_ready
);

    logic             out_valid_reg, out_valid_next;
    svd_pkg::result_t out_res_reg, out_res_next;
    logic             skid_valid_reg, skid_valid_next;
    svd_pkg::result_t skid_res_reg, skid_res_next;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_res_next    = out_res_reg;
        skid_valid_next = skid_valid_reg;
        skid_res_next   = skid_res_reg;

        if (out_ready || !out_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_res_next    = skid_res_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = in_valid;
                out_res_next   = in_res;
            end
        end
        else if (in_valid)
        begin
            // park the new transaction while the output stalls
            skid_valid_next = 1'b1;
            skid_res_next   = in_res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_res_reg  <= out_res_next;
        skid_res_reg <= skid_res_next;
    end

    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;

endmodule

FILE: rtl/signed_varint_stream_decoder_top.sv
// channel | dir | handshake               | payload
// s_axis  | in  | s_axis_tvalid/tready    | tdata[7:0] data_byte, tlast payload_end
// m_axis  | out | m_axis_tvalid/tready    | tdata[63:0] decoded_value, tuser[1:0] status
//
// One byte accepted per cycle while s_axis_tready is high; a result is registered in the output stage.
// Decode is one shift-or, compare and negate between the state and output registers.
// Reset clears the accumulator and waits for a first byte; no output pending.
// A two-entry output stage keeps s_axis_tready high through a one-result stall;
// s_axis_tready drops only once both output entries hold results.
`include "assert_macros.svh"

module signed_varint_stream_decoder_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tlast,   // payload_end
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // [63:0] decoded_value
    output logic [1:0]  m_axis_tuser    // [1:0] status
);

    logic             in_fire;
    logic             res_valid;
    svd_pkg::result_t res;
    svd_pkg::result_t out_res;

    assign in_fire = s_axis_tvalid && s_axis_tready;

    svd_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_fire     (in_fire),
        .data_byte   (s_axis_tdata),
        .payload_end (s_axis_tlast),
        .res_valid   (res_valid),
        .res         (res)
    );

    svd_skid u_skid (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (res_valid),
        .in_res    (res),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_res   (out_res),
        .out_ready (m_axis_tready)
    );

    assign m_axis_tdata = out_res.value;
    assign m_axis_tuser = out_res.status;

    `ASSERT_SAME(a_err_zero, m_axis_tvalid && m_axis_tuser != svd_pkg::ST_OK,
        m_axis_tdata == 64'd0, "error result carries a nonzero value")
    `ASSERT_SAME(a_no_min, m_axis_tvalid,
        m_axis_tdata != 64'h8000_0000_0000_0000, "result equals the int64 minimum")
    `ASSERT_SAME(a_stall_full, !s_axis_tready,
        m_axis_tvalid, "input held off with an empty output")
    `ASSERT_NEXT(a_stall_rise, s_axis_tready && m_axis_tvalid && !m_axis_tready && !res_valid,
        s_axis_tready, "input held off without a parked result")

endmodule

FILE: dv/tb_signed_varint_stream_decoder_top.sv
module tb_signed_varint_stream_decoder_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_CYCLES = 8;
    localparam int MAX_REPORTS = 10;
    localparam logic [63:0] INT64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

    typedef enum int {
        PACE_NORMAL,
        PACE_NONE,
        PACE_HEAVY
    } pace_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'd0;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;

    svd_pkg::result_t decoded_results[$];
    svd_pkg::result_t head_result;

    logic [63:0] acc_mag = 64'd0;
    logic [6:0]  acc_shift = svd_pkg::FIRST_SHIFT;
    logic        acc_neg = 1'b0;
    logic        acc_busy = 1'b0;

    pace_t       send_pace = PACE_NORMAL;
    pace_t       recv_pace = PACE_NORMAL;
    int          stall_left = 0;
    int          bytes_sent = 0;
    int          mismatches = 0;
    int          cycle_count = 0;

    signed_varint_stream_decoder_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic int pick_idle(input pace_t pace);
        int r;
        r = $urandom_range(0, 99);
        if (pace == PACE_NONE)
            return 0;
        if (pace == PACE_HEAVY)
            return (r < 50) ? $urandom_range(1, 8) : $urandom_range(0, 1);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // receiver side: hold tready low for random stretches
    always @(posedge clk)
    begin
        int len;
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            len = pick_idle(recv_pace);
            if ($urandom_range(0, 3) != 0 && recv_pace != PACE_HEAVY)
                len = 0;
            if (len > 0)
            begin
                m_axis_tready <= 1'b0;
                stall_left <= len - 1;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    task automatic clear_decoder_state();
        acc_mag = 64'd0;
        acc_shift = svd_pkg::FIRST_SHIFT;
        acc_neg = 1'b0;
        acc_busy = 1'b0;
    endtask

    task automatic decode_byte(input logic [7:0] b, input logic last);
        svd_pkg::result_t r;
        logic             done;
        done = 1'b0;
        r.value = '0;
        r.status = svd_pkg::ST_OK;
        if (!acc_busy)
        begin
            acc_mag = {58'd0, b[5:0]};
            acc_neg = b[6];
            acc_shift = svd_pkg::FIRST_SHIFT;
        end
        else if (acc_shift > svd_pkg::LAST_SHIFT)
        begin
            // consume the byte, whatever its flags
            r.status = svd_pkg::ST_TOO_LONG;
            done = 1'b1;
        end
        else
        begin
            acc_mag = acc_mag + ({57'd0, b[6:0]} << acc_shift[5:0]);
            acc_shift = acc_shift + svd_pkg::SHIFT_STEP;
        end
        if (!done)
        begin
            if (b[7])
            begin
                if (last)
                begin
                    r.status = svd_pkg::ST_NO_TERM;
                    done = 1'b1;
                end
                else
                    acc_busy = 1'b1;
            end
            else
            begin
                done = 1'b1;
                if (acc_mag > INT64_MAX)
                    r.status = svd_pkg::ST_OVERFLOW;
                else
                    r.value = acc_neg ? 64'd0 - acc_mag : acc_mag;
            end
        end
        if (done)
        begin
            decoded_results.insert(decoded_results.size(), r);
            clear_decoder_state();
        end
    endtask

    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        gap = pick_idle(send_pace);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= 8'($urandom);
            s_axis_tlast <= 1'($urandom);
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= b;
        s_axis_tlast <= last;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        decode_byte(b, last);
        bytes_sent++;
    endtask

    task automatic report_mismatch(input string what, input svd_pkg::result_t want);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("mismatch (%s): expected value %h status %0d, got value %h status %0d",
                     what, want.value, want.status, m_axis_tdata, m_axis_tuser);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (decoded_results.size() == 0)
            begin
                head_result.value = '0;
                head_result.status = svd_pkg::ST_OK;
                report_mismatch("unexpected transaction", head_result);
            end
            else
            begin
                head_result = decoded_results.pop_front();
                if (m_axis_tdata !== head_result.value || m_axis_tuser !== head_result.status)
                    report_mismatch("wrong field", head_result);
            end
        end
    end

    // first byte, then a run of continuation fill bytes, then a closing byte
    task automatic send_long(input logic [7:0] first, input logic [7:0] fill, input int count,
                             input logic [7:0] closing, input logic closing_last);
        send_byte(first, 1'b0);
        repeat (count) send_byte(fill, 1'b0);
        send_byte(closing, closing_last);
    endtask

    task automatic test_directed();
        send_byte(8'h00, 1'b0);
        send_byte(8'h3F, 1'b0);
        send_byte(8'h40, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(8'h05, 1'b1);
        send_byte(8'h80, 1'b1);
        send_byte(8'hC1, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(8'h81, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_long(8'hBF, 8'hFF, 8, 8'h01, 1'b1);
        send_long(8'hFF, 8'hFF, 8, 8'h01, 1'b0);
        send_long(8'hBF, 8'hFF, 8, 8'h02, 1'b0);
        send_long(8'h80, 8'h80, 8, 8'h7D, 1'b0);
        send_long(8'h80, 8'h80, 9, 8'hFF, 1'b1);
        send_byte(8'h3F, 1'b0);
        send_long(8'hC0, 8'h80, 9, 8'h00, 1'b0);
        send_long(8'h80, 8'h80, 9, 8'h80, 1'b0);
        send_byte(8'h7F, 1'b1);
    endtask

    task automatic send_value_sequence();
        int       r;
        int       len;
        int       cut;
        logic [7:0] b;
        logic     last;
        logic     end_flag;
        r = $urandom_range(0, 99);
        if (r < 40)
            len = $urandom_range(1, 2);
        else if (r < 70)
            len = $urandom_range(3, 5);
        else if (r < 88)
            len = $urandom_range(6, 9);
        else if (r < 96)
            len = 10;
        else
            len = $urandom_range(11, 12);
        cut = (len > 1 && $urandom_range(0, 9) == 0) ? $urandom_range(0, len - 2) : -1;
        end_flag = ($urandom_range(0, 2) == 0);
        for (int i = 0; i < len; i++)
        begin
            r = $urandom_range(0, 9);
            b = (r == 0) ? 8'hFF : (r == 1) ? 8'h00 : 8'($urandom);
            b[7] = (i < len - 1);
            last = (i == len - 1) ? end_flag : 1'b0;
            if (i == cut)
                last = 1'b1;
            send_byte(b, last);
            if (i == cut)
                break;
        end
    endtask

    task automatic test_random_sequences(input int budget);
        int start;
        start = bytes_sent;
        while (bytes_sent - start < budget)
            send_value_sequence();
    endtask

    task automatic test_noise(input int budget);
        repeat (budget) send_byte(8'($urandom), ($urandom_range(0, 3) == 0));
    endtask

    task automatic test_back_to_back(input int budget);
        int start;
        send_pace = PACE_NONE;
        recv_pace = PACE_NONE;
        start = bytes_sent;
        while (bytes_sent - start < budget)
            send_value_sequence();
        send_pace = PACE_NORMAL;
        recv_pace = PACE_NORMAL;
    endtask

    task automatic test_receiver_stall(input int budget);
        int start;
        send_pace = PACE_NONE;
        recv_pace = PACE_HEAVY;
        start = bytes_sent;
        while (bytes_sent - start < budget)
        begin
            if ($urandom_range(0, 1) == 0)
                send_byte(8'($urandom) & 8'h7F, 1'b0);
            else
                send_value_sequence();
        end
        send_pace = PACE_NORMAL;
        recv_pace = PACE_NORMAL;
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random_sequences(700);
        test_noise(150);
        test_back_to_back(180);
        test_receiver_stall(100);
        s_axis_tvalid <= 1'b0;
        while (decoded_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && decoded_results.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+rtl
rtl/svd_pkg.sv
rtl/svd_core.sv
rtl/svd_skid.sv
rtl/signed_varint_stream_decoder_top.sv
dv/tb_signed_varint_stream_decoder_top.sv
